### hw/rtl/opq_pkg.sv
// Package for the ordered priority queue: transfer structs, action and status
// codes, slot and cell control types. No dependencies.
package opq_pkg;

  localparam int OPQ_DEPTH = 16;

  localparam logic [2:0] ACT_CLEAR      = 3'd0;
  localparam logic [2:0] ACT_APPEND     = 3'd1;
  localparam logic [2:0] ACT_INSERT     = 3'd2;
  localparam logic [2:0] ACT_REMOVE_ID  = 3'd3;
  localparam logic [2:0] ACT_REMOVE_PRI = 3'd4;
  localparam logic [2:0] ACT_POP        = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] item_id;
    logic [7:0] priority_req;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_id;
    logic [7:0] out_priority;
    logic       is_empty;
    logic [4:0] entry_count;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] id;
    logic [7:0] pri;
  } slot_t;

  // per-cycle instruction to one cell
  typedef enum logic [2:0] {
    MV_HOLD,
    MV_LEFT,   // take the slot of the neighbor toward the head
    MV_RIGHT,  // take the slot of the neighbor toward the tail
    MV_NEW,    // load the incoming entry
    MV_CLEAR
  } cell_move_t;

  // local compare results, all gated by the slot's valid bit
  typedef struct packed {
    logic pri_ge;
    logic pri_le;
    logic pri_eq;
    logic id_eq;
  } cell_flags_t;

endpackage

### hw/rtl/opq_cell.sv
// One slot of the queue: holds an entry, compares it against the key and
// moves to/from its neighbors. Depends on opq_pkg.
module opq_cell (
  input  logic                clk,
  input  logic                rst,
  input  opq_pkg::cell_move_t move,
  input  opq_pkg::slot_t      left,
  input  opq_pkg::slot_t      right,
  input  logic [7:0]          key_id,
  input  logic [7:0]          key_pri,
  output opq_pkg::slot_t      slot,
  output opq_pkg::cell_flags_t flags
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      unique case (move)
        opq_pkg::MV_HOLD: ;
        opq_pkg::MV_LEFT:  slot <= left;
        opq_pkg::MV_RIGHT: slot <= right;
        opq_pkg::MV_NEW:   slot <= '{valid: 1'b1, id: key_id, pri: key_pri};
        opq_pkg::MV_CLEAR: slot.valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    flags.pri_ge = slot.valid && (slot.pri >= key_pri);
    flags.pri_le = slot.valid && (slot.pri <= key_pri);
    flags.pri_eq = slot.valid && (slot.pri == key_pri);
    flags.id_eq  = slot.valid && (slot.id == key_id);
  end

endmodule

### hw/rtl/opq_prefix.sv
// Log-depth inclusive prefix OR from bit 0 upward (bit i = OR of din[i:0]).
// Used to locate the first hit in the cell row. No dependencies.
module opq_prefix #(
  parameter int W = 16
) (
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  localparam int LV = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0] lvl [LV+1];

  assign lvl[0] = din;

  for (genvar k = 0; k < LV; k++) begin : g_lvl
    localparam int SH = 1 << k;
    for (genvar i = 0; i < W; i++) begin : g_bit
      if (i >= SH) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-SH];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign dout = lvl[LV];

endmodule

### hw/rtl/ordered_priority_queue.sv
// Top level of the ordered priority queue: a row of opq_cell slots steered by
// prefix scans (opq_prefix). Depends on opq_pkg, opq_cell, opq_prefix.
//
//   port          dir  width        transfer
//   start/request in   1 + 19       at clk edge with start && !busy
//   done/result   out  1 + 24       one cycle, taken at the edge ending it
//
// In each action the accepting edge latches the command; while busy, every cell
// updates at once and the result is registered, then shown with done while
// busy is already low again. Each action is one compare / prefix-scan / shift
// step; a new request can be accepted while the previous result is shown.
// Synchronous reset empties the queue; no clearing pass is needed.
// The receiver cannot stall; results are never held back.
module ordered_priority_queue #(
  parameter int DEPTH = opq_pkg::OPQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  opq_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output opq_pkg::result_t  result
);

  localparam int CntW = $clog2(DEPTH + 1);

  opq_pkg::request_t    cmd;
  logic [CntW-1:0]      count;
  logic [CntW-1:0]      count_next;
  opq_pkg::result_t     result_next;

  opq_pkg::slot_t       slots [DEPTH];
  opq_pkg::cell_flags_t flags [DEPTH];
  opq_pkg::cell_move_t  moves [DEPTH];

  logic [DEPTH-1:0] ins_hit, ins_rev, ins_rev_pfx, ins_sfx;
  logic [DEPTH-1:0] rem_hit, rem_pfx, first_hit, pri_eq_vec;
  logic [DEPTH-1:0] id_plane  [8];
  logic [DEPTH-1:0] pri_plane [8];
  logic [7:0]       sel_id, sel_pri;
  logic             full, found;
  logic [CntW+4:0]  count_ext;

  wire accept = start && !busy;

  // ---- cell row ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    opq_pkg::slot_t lft, rgt;
    if (i == 0) begin : g_head
      assign lft = '0;
    end else begin : g_mid_l
      assign lft = slots[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rgt = '0;
    end else begin : g_mid_r
      assign rgt = slots[i+1];
    end
    opq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .move    (moves[i]),
      .left    (lft),
      .right   (rgt),
      .key_id  (cmd.item_id),
      .key_pri (cmd.priority_req),
      .slot    (slots[i]),
      .flags   (flags[i])
    );
  end

  // ---- hit vectors ----
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      // append treats every held entry as "at least as high", so it lands at the tail
      ins_hit[i]    = (cmd.action == opq_pkg::ACT_INSERT) ? flags[i].pri_ge : slots[i].valid;
      pri_eq_vec[i] = flags[i].pri_eq;
      unique case (cmd.action)
        opq_pkg::ACT_REMOVE_ID:  rem_hit[i] = flags[i].id_eq;
        opq_pkg::ACT_REMOVE_PRI: rem_hit[i] = flags[i].pri_le;
        opq_pkg::ACT_POP:        rem_hit[i] = (i == 0) && slots[i].valid;
        default:                 rem_hit[i] = 1'b0;
      endcase
      ins_rev[i] = ins_hit[DEPTH-1-i];
    end
  end

  // insert position = one past the last hit, found through a suffix OR
  opq_prefix #(.W(DEPTH)) u_ins_scan (.din(ins_rev), .dout(ins_rev_pfx));
  opq_prefix #(.W(DEPTH)) u_rem_scan (.din(rem_hit), .dout(rem_pfx));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ins_sfx[i] = ins_rev_pfx[DEPTH-1-i];
    end
    first_hit[0] = rem_hit[0];
    for (int i = 1; i < DEPTH; i++) begin
      first_hit[i] = rem_hit[i] && !rem_pfx[i-1];
    end
  end

  assign full  = (count >= CntW'(DEPTH));
  // remove by priority stops at the first entry not above the key; equal is required
  assign found = (cmd.action == opq_pkg::ACT_REMOVE_PRI) ? |(first_hit & pri_eq_vec)
                                                         : rem_pfx[DEPTH-1];

  // ---- removed entry select, one AND-OR tree per bit ----
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      for (int i = 0; i < DEPTH; i++) begin
        id_plane[b][i]  = first_hit[i] && slots[i].id[b];
        pri_plane[b][i] = first_hit[i] && slots[i].pri[b];
      end
      sel_id[b]  = |id_plane[b];
      sel_pri[b] = |pri_plane[b];
    end
  end

  // ---- cell moves ----
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      moves[i] = opq_pkg::MV_HOLD;
      if (busy) begin
        case (cmd.action) inside
          opq_pkg::ACT_CLEAR: moves[i] = opq_pkg::MV_CLEAR;
          opq_pkg::ACT_APPEND, opq_pkg::ACT_INSERT: begin
            if (!full) begin
              if (i > 0 && !ins_sfx[(i > 0) ? i - 1 : 0]) begin
                moves[i] = opq_pkg::MV_LEFT;
              end else if (!ins_sfx[i]) begin
                moves[i] = opq_pkg::MV_NEW;
              end
            end
          end
          opq_pkg::ACT_REMOVE_ID, opq_pkg::ACT_REMOVE_PRI, opq_pkg::ACT_POP: begin
            if (found && rem_pfx[i]) moves[i] = opq_pkg::MV_RIGHT;
          end
          default: ;
        endcase
      end
    end
  end

  // ---- result ----
  always_comb begin
    count_next               = count;
    result_next.status       = opq_pkg::ST_DONE;
    result_next.out_id       = '0;
    result_next.out_priority = '0;
    case (cmd.action) inside
      opq_pkg::ACT_CLEAR: count_next = '0;
      opq_pkg::ACT_APPEND, opq_pkg::ACT_INSERT: begin
        if (full) begin
          result_next.status = opq_pkg::ST_FULL;
        end else begin
          result_next.out_id       = cmd.item_id;
          result_next.out_priority = cmd.priority_req;
          count_next               = count + CntW'(1);
        end
      end
      opq_pkg::ACT_REMOVE_ID, opq_pkg::ACT_REMOVE_PRI, opq_pkg::ACT_POP: begin
        if (found) begin
          result_next.out_id       = sel_id;
          result_next.out_priority = sel_pri;
          count_next               = count - CntW'(1);
        end else begin
          result_next.status = opq_pkg::ST_MISS;
        end
      end
      default: ;
    endcase
    count_ext                = {5'b0, count_next};
    result_next.is_empty     = (count_next == '0);
    result_next.entry_count  = count_ext[4:0];
  end

  // ---- control and payload registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd <= request;
    if (busy) result <= result_next;
  end

  // ---- assertions ----
  logic [DEPTH-1:0] valid_vec;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) valid_vec[i] = slots[i].valid;
  end

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("action did not finish in one busy cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("entry count above capacity");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("valid slots disagree with entry count");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (count == '0)))
    else $error("empty flag disagrees with entry count");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == opq_pkg::ST_FULL) |-> $stable(count))
    else $error("refused entry changed the count");

endmodule
